[rtl/core/assert_macros.svh]
// Assertion helpers shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[rtl/core/hds_pkg.sv]
package hds_pkg;

   // Storage depth default
   localparam int DEFAULT_MAX_POINTS = 1024;

   // Field widths
   localparam int OP_W       = 2;
   localparam int INDEX_W    = 10;
   localparam int TEMP_W     = 32;
   localparam int KIND_W     = 2;
   localparam int NPTS_W     = 11;
   localparam int COEF_W     = 16;
   localparam int SWEEPS_W   = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // Datapath widths: Laplacian, product, shifted delta, sum
   localparam int LAP_W   = 35;
   localparam int PROD_W  = LAP_W + COEF_W + 1;
   localparam int FRAC_W  = 16;
   localparam int DELTA_W = PROD_W - FRAC_W;
   localparam int SUM_W   = DELTA_W + 1;

   // Opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_POINTS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIFF_COEF   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_COUNT = 2'd2;

   // Register reset values
   localparam logic [NPTS_W-1:0]   NUM_POINTS_RST  = 11'd1024;
   localparam logic [COEF_W-1:0]   DIFF_COEF_RST   = 16'd32768;
   localparam logic [SWEEPS_W-1:0] SWEEP_COUNT_RST = 17'd100000;

   // Saturation limits
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = 32'sh8000_0000;

   // Read issue toward the sweep pipeline
   typedef struct packed {
      logic valid;   // sweep read issued this cycle
      logic tap;     // address is at least two, a full stencil window follows
   } sweep_rd_type;

   // Writeback and status from the sweep pipeline
   typedef struct packed {
      logic en;      // write back one interior point
      logic busy;    // some stage still holds a point
   } sweep_stat_type;

   // One queued result
   typedef struct packed {
      logic signed [TEMP_W-1:0] read_value;
      logic [KIND_W-1:0]        kind;
   } rsp_item_type;

endpackage

[rtl/core/hds_req_if.sv]
interface hds_req_if;
   logic                             valid;
   logic                             ready;
   logic [hds_pkg::OP_W-1:0]         op;
   logic [hds_pkg::INDEX_W-1:0]      index;
   logic signed [hds_pkg::TEMP_W-1:0] value;

   modport source (output valid, op, index, value, input ready);
   modport sink   (input valid, op, index, value, output ready);
endinterface

[rtl/core/hds_rsp_if.sv]
interface hds_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [hds_pkg::TEMP_W-1:0] read_value;
   logic [hds_pkg::KIND_W-1:0]       kind;

   modport source (output valid, read_value, kind, input ready);
   modport sink   (input valid, read_value, kind, output ready);
endinterface

[rtl/core/hds_ram.sv]
module hds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/hds_sweep.sv]
module hds_sweep #(
   parameter int AW = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [hds_pkg::COEF_W-1:0]           coef,
   input  hds_pkg::sweep_rd_type                rd_ctl,
   input  logic [AW-1:0]                        rd_addr,
   input  logic signed [hds_pkg::TEMP_W-1:0]    rd_data,
   output hds_pkg::sweep_stat_type              stat,
   output logic [AW-1:0]                        wr_addr,
   output logic signed [hds_pkg::TEMP_W-1:0]    wr_data
);

   // Data stage: memory output arrives, window of the two older points
   logic                              d_valid_ff;
   logic                              d_tap_ff;
   logic [AW-1:0]                     d_addr_ff;
   logic signed [hds_pkg::TEMP_W-1:0] win0_ff;
   logic signed [hds_pkg::TEMP_W-1:0] win1_ff;
   // Laplacian stage
   logic                              s1_valid_ff;
   logic signed [hds_pkg::LAP_W-1:0]  lap_ff;
   logic signed [hds_pkg::TEMP_W-1:0] s1_cur_ff;
   logic [AW-1:0]                     s1_addr_ff;
   // Product stage
   logic                              s2_valid_ff;
   logic signed [hds_pkg::PROD_W-1:0] prod_ff;
   logic signed [hds_pkg::TEMP_W-1:0] s2_cur_ff;
   logic [AW-1:0]                     s2_addr_ff;

   logic signed [hds_pkg::LAP_W-1:0]   lap_in;
   logic signed [hds_pkg::PROD_W-1:0]  prod_in;
   logic signed [hds_pkg::DELTA_W-1:0] delta;
   logic signed [hds_pkg::SUM_W-1:0]   sum;

   // Left minus twice center plus right, exact
   assign lap_in = hds_pkg::LAP_W'(win0_ff) - (hds_pkg::LAP_W'(win1_ff) <<< 1)
                 + hds_pkg::LAP_W'(rd_data);

   // Coefficient is unsigned Q0.16
   assign prod_in = lap_ff * $signed({1'b0, coef});

   // Arithmetic shift floors toward minus infinity
   assign delta = prod_ff[hds_pkg::PROD_W-1:hds_pkg::FRAC_W];
   assign sum   = hds_pkg::SUM_W'(s2_cur_ff) + hds_pkg::SUM_W'(delta);

   // Saturate to the signed 32-bit range
   always_comb begin
      if (sum > hds_pkg::SUM_W'(hds_pkg::TEMP_MAX)) begin
         wr_data = hds_pkg::TEMP_MAX;
      end else if (sum < hds_pkg::SUM_W'(hds_pkg::TEMP_MIN)) begin
         wr_data = hds_pkg::TEMP_MIN;
      end else begin
         wr_data = sum[hds_pkg::TEMP_W-1:0];
      end
   end

   assign wr_addr   = s2_addr_ff;
   assign stat.en   = s2_valid_ff;
   assign stat.busy = d_valid_ff | s1_valid_ff | s2_valid_ff;

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         d_valid_ff  <= rd_ctl.valid;
         s1_valid_ff <= d_valid_ff & d_tap_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Shift the window and carry payload down the stages
   always_ff @(posedge clock) begin
      d_tap_ff  <= rd_ctl.tap;
      d_addr_ff <= rd_addr;
      if (d_valid_ff) begin
         win0_ff <= win1_ff;
         win1_ff <= rd_data;
      end
      lap_ff     <= lap_in;
      s1_cur_ff  <= win1_ff;
      s1_addr_ff <= AW'(d_addr_ff - 1'b1);
      prod_ff    <= prod_in;
      s2_cur_ff  <= s1_cur_ff;
      s2_addr_ff <= s1_addr_ff;
   end

endmodule

[rtl/core/hds_rsp_queue.sv]
`include "assert_macros.svh"

module hds_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hds_pkg::rsp_item_type push_item,
   output logic                  space,
   hds_rsp_if.source             rsp_if
);

   hds_pkg::rsp_item_type entry_ff [2];
   logic                  head_ff;
   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic                  tail;
   logic                  pop;

   assign pop   = rsp_if.valid & rsp_if.ready;
   assign tail  = head_ff ^ count_ff[0];
   assign space = (count_ff != 2'd2);
   assign count_in = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   assign rsp_if.valid      = (count_ff != 2'd0);
   assign rsp_if.read_value = entry_ff[head_ff].read_value;
   assign rsp_if.kind       = entry_ff[head_ff].kind;

   // Track fill level and head
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            head_ff <= ~head_ff;
         end
      end
   end

   // Store the pushed result at the tail
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail] <= push_item;
      end
   end

   `CHECK_IMPL(a_no_push_when_full, clock, reset, push, count_ff != 2'd2, "push into full queue")
   `CHECK_ALWAYS(a_count_bound, clock, reset, count_ff != 2'd3, "queue count out of range")

endmodule

[rtl/core/heat_diffusion_1d_stencil.sv]
// Writes, op 3 and runs with no work answer in the cycle after the transfer; reads answer
// once the registered memory output is queued from the read state. During a run the single
// memory read port walks the whole rod once per sweep, then the three-stage update pipeline
// drains. Writes transfer every cycle while the queue has space; reads and runs hold input
// until answered. Synchronous active-high reset restores register defaults, clears control
// and queue; the point memory is not cleared and holds undefined data until written.
`include "assert_macros.svh"

module heat_diffusion_1d_stencil #(
   parameter int MAX_POINTS = hds_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                               clock,
   input  logic                               reset,
   hds_req_if.sink                            req_if,
   hds_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [hds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RUN_READ,
      S_RUN_DRAIN
   } state_type;

   state_type                          state_ff;
   logic [AW-1:0]                      rd_addr_ff;
   logic [hds_pkg::SWEEPS_W-1:0]       sweep_counter_ff;
   logic                               read_oor_ff;

   logic [hds_pkg::NPTS_W-1:0]         num_points_ff;
   logic [hds_pkg::COEF_W-1:0]         diff_coef_ff;
   logic [hds_pkg::SWEEPS_W-1:0]       sweep_count_ff;

   logic [CW-1:0]                      n_eff;
   logic [CW-1:0]                      n_last;
   logic                               in_range;
   logic                               accept;
   logic                               run_empty;
   logic                               last_sweep;
   logic                               space;

   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_wr_addr;
   logic signed [hds_pkg::TEMP_W-1:0]  ram_wr_data;
   logic                               ram_rd_en;
   logic [AW-1:0]                      ram_rd_addr;
   logic signed [hds_pkg::TEMP_W-1:0]  ram_rd_data;

   hds_pkg::sweep_rd_type              sweep_rd;
   hds_pkg::sweep_stat_type            sweep_stat;
   logic [AW-1:0]                      sweep_wr_addr;
   logic signed [hds_pkg::TEMP_W-1:0]  sweep_wr_data;

   logic                               push;
   hds_pkg::rsp_item_type              push_item;

   // Clamp the rod length to storage
   assign n_eff = (32'(num_points_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(num_points_ff);
   assign n_last     = CW'(n_eff - 1'b1);
   assign in_range   = (32'(req_if.index) < MAX_POINTS);
   assign run_empty  = (sweep_count_ff == '0) || (32'(n_eff) < 3);
   assign last_sweep = (hds_pkg::SWEEPS_W'(sweep_counter_ff + 1'b1) == sweep_count_ff);

   assign req_if.ready = (state_ff == S_IDLE) && space;
   assign accept       = req_if.valid & req_if.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff  <= hds_pkg::NUM_POINTS_RST;
         diff_coef_ff   <= hds_pkg::DIFF_COEF_RST;
         sweep_count_ff <= hds_pkg::SWEEP_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            hds_pkg::CSR_NUM_POINTS:  num_points_ff  <= csr_wdata[hds_pkg::NPTS_W-1:0];
            hds_pkg::CSR_DIFF_COEF:   diff_coef_ff   <= csr_wdata[hds_pkg::COEF_W-1:0];
            hds_pkg::CSR_SWEEP_COUNT: sweep_count_ff <= csr_wdata[hds_pkg::SWEEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Steer memory ports and push results
   always_comb begin
      ram_wr_en      = 1'b0;
      ram_wr_addr    = AW'(req_if.index);
      ram_wr_data    = req_if.value;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = AW'(req_if.index);
      sweep_rd.valid = 1'b0;
      sweep_rd.tap   = 1'b0;
      push           = 1'b0;
      push_item.read_value = '0;
      push_item.kind       = hds_pkg::KIND_WRITE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.op)
                  hds_pkg::OP_WRITE: begin
                     ram_wr_en = in_range;
                     push      = 1'b1;
                  end
                  hds_pkg::OP_RUN: begin
                     push           = run_empty;
                     push_item.kind = hds_pkg::KIND_RUN;
                  end
                  hds_pkg::OP_READ: begin
                     ram_rd_en = in_range;
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            push                 = 1'b1;
            push_item.kind       = hds_pkg::KIND_READ;
            push_item.read_value = read_oor_ff ? '0 : ram_rd_data;
         end
         S_RUN_READ: begin
            ram_rd_en      = 1'b1;
            ram_rd_addr    = rd_addr_ff;
            sweep_rd.valid = 1'b1;
            sweep_rd.tap   = (32'(rd_addr_ff) >= 2);
         end
         S_RUN_DRAIN: begin
            push           = !sweep_stat.busy && last_sweep;
            push_item.kind = hds_pkg::KIND_RUN;
         end
         default: ;
      endcase
      // Sweep writeback owns the write port during a run
      if (sweep_stat.en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_wr_addr;
         ram_wr_data = sweep_wr_data;
      end
   end

   // Sequence items and sweeps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rd_addr_ff       <= '0;
         sweep_counter_ff <= '0;
         read_oor_ff      <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  priority if (req_if.op == hds_pkg::OP_RUN) begin
                     sweep_counter_ff <= '0;
                     rd_addr_ff       <= '0;
                     if (!run_empty) begin
                        state_ff <= S_RUN_READ;
                     end
                  end else if (req_if.op == hds_pkg::OP_READ) begin
                     read_oor_ff <= !in_range;
                     state_ff    <= S_READ;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_IDLE;
            end
            S_RUN_READ: begin
               if (CW'(rd_addr_ff) == n_last) begin
                  state_ff <= S_RUN_DRAIN;
               end else begin
                  rd_addr_ff <= AW'(rd_addr_ff + 1'b1);
               end
            end
            S_RUN_DRAIN: begin
               // Hold the next sweep until every writeback has landed
               if (!sweep_stat.busy) begin
                  sweep_counter_ff <= hds_pkg::SWEEPS_W'(sweep_counter_ff + 1'b1);
                  rd_addr_ff       <= '0;
                  state_ff         <= last_sweep ? S_IDLE : S_RUN_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   hds_ram #(
      .WIDTH (hds_pkg::TEMP_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hds_sweep #(
      .AW (AW)
   ) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .coef    (diff_coef_ff),
      .rd_ctl  (sweep_rd),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data),
      .stat    (sweep_stat),
      .wr_addr (sweep_wr_addr),
      .wr_data (sweep_wr_data)
   );

   hds_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (space),
      .rsp_if    (rsp_if)
   );

   `CHECK_IMPL(a_sweep_start_drained, clock, reset, (state_ff == S_RUN_READ) && (rd_addr_ff == '0), !sweep_stat.busy, "sweep started with writebacks pending")
   `CHECK_IMPL(a_writeback_in_run, clock, reset, sweep_stat.en, (state_ff == S_RUN_READ) || (state_ff == S_RUN_DRAIN), "writeback outside a run")

endmodule
